### hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and hex helpers for the URL percent
// decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Most bytes one request can produce.
    localparam int unsigned MAX_BYTES = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // The decoded bytes of one request, first byte in slot 0.
    typedef struct packed {
        logic [1:0]                 count;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } burst_t;

    // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 hold
    // the digit value.
    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b inside {[8'h30:8'h39]}) begin
            v = {1'b0, b[3:0]};
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, 4'(b[3:0] + 4'd9)};
        end
        return v;
    endfunction

    // Uppercase hex character for one nibble.
    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = {4'h3, n};
        end
        else begin
            c = 8'(8'h37 + {4'h0, n});
        end
        return c;
    endfunction

endpackage

### hw/rtl/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Input register, escape state and the combinational decode of one request
// into a burst of up to three bytes.
// ----------------------------------------------------------------------------
module upd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  upd_pkg::in_item_t in_data,
    input  logic              plus_as_space,
    input  logic              space,
    output logic              burst_valid,
    output upd_pkg::burst_t   burst
);
    import upd_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic       take;
    logic       accept;
    logic [4:0] hex;
    logic [7:0] b;

    // The held request moves on whenever the burst register has room.
    assign take        = in_valid_reg && space;
    assign in_stall    = in_valid_reg && !space;
    assign accept      = in_valid && !in_stall;
    assign burst_valid = in_valid_reg;

    assign b   = in_item_reg.text_byte;
    assign hex = hex_value(b);

    always_comb
    begin
        burst       = '0;
        phase_next  = PH_IDLE;
        nibble_next = nibble_reg;
        case (phase_reg)
            PH_FIRST:
            begin
                if (hex[4]) begin
                    burst.count    = 2'd2;
                    burst.bytes[0] = CHAR_PERCENT;
                    burst.bytes[1] = b;
                end
                else begin
                    nibble_next = hex[3:0];
                    phase_next  = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (hex[4]) begin
                    burst.count    = 2'd3;
                    burst.bytes[0] = CHAR_PERCENT;
                    burst.bytes[1] = hex_char(nibble_reg);
                    burst.bytes[2] = b;
                end
                else begin
                    burst.count    = 2'd1;
                    burst.bytes[0] = {nibble_reg, hex[3:0]};
                end
            end
            default:
            begin
                if (b == CHAR_PLUS) begin
                    burst.count    = 2'd1;
                    burst.bytes[0] = plus_as_space ? CHAR_SPACE : CHAR_PLUS;
                end
                else if (b == CHAR_PERCENT) begin
                    phase_next = PH_FIRST;
                end
                else begin
                    burst.count    = 2'd1;
                    burst.bytes[0] = b;
                end
            end
        endcase
        if (in_item_reg.end_of_text) begin
            phase_next  = PH_IDLE;
            nibble_next = 4'h0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            nibble_reg   <= 4'h0;
        end
        else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end
            else if (take) begin
                in_valid_reg <= 1'b0;
            end
            if (take) begin
                phase_reg  <= phase_next;
                nibble_reg <= nibble_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_item_reg <= in_data;
        end
    end

    // An end-of-text request always leaves the escape state cleared.
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_item_reg.end_of_text |=> phase_reg == PH_IDLE && nibble_reg == 4'h0)
        else $error("escape state not cleared after end of text");

    // A held request that could not move on is still there next cycle.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !space |=> in_valid_reg && $stable(in_item_reg))
        else $error("held request lost");

endmodule

### hw/rtl/upd_emit.sv
// ----------------------------------------------------------------------------
// upd_emit
// Burst register that hands the decoded bytes of one request to the output
// one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module upd_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               burst_valid,
    input  upd_pkg::burst_t    burst,
    output logic               space,
    output logic               out_valid,
    input  logic               out_stall,
    output upd_pkg::out_item_t out_data
);
    import upd_pkg::*;

    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [1:0]                left_reg;
    logic [1:0]                pos_reg;
    logic                      out_take;

    assign out_valid = left_reg != 2'd0;
    assign out_take  = out_valid && !out_stall;
    // Room for a new burst once the current one is gone or leaves now.
    assign space     = (left_reg == 2'd0) || (left_reg == 2'd1 && !out_stall);

    always_comb
    begin
        case (pos_reg)
            2'd0:    out_data.plain_byte = bytes_reg[0];
            2'd1:    out_data.plain_byte = bytes_reg[1];
            default: out_data.plain_byte = bytes_reg[2];
        endcase
        out_data.run_last = left_reg == 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_reg <= 2'd0;
            pos_reg  <= 2'd0;
        end
        else if (burst_valid && space) begin
            left_reg <= burst.count;
            pos_reg  <= 2'd0;
        end
        else if (out_take) begin
            left_reg <= left_reg - 2'd1;
            pos_reg  <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_valid && space) begin
            bytes_reg <= burst.bytes;
        end
    end

    // The read position never runs past the bytes of the burst.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} + {1'b0, left_reg}) <= 3'(MAX_BYTES))
        else $error("burst read position out of range");

    // A loaded burst starts with its full byte count.
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && space |=> left_reg == $past(burst.count) && pos_reg == 2'd0)
        else $error("burst not loaded");

endmodule

### hw/rtl/url_percent_decoder.sv
// A request waits in the decode input register, is decoded combinationally
// and loads the emit burst register, which drives the output. Throughput:
// one request per cycle when each gives at most one byte and out_stall is
// low; a longer burst holds the single output register until it drains.
// Reset (rst_n low, asynchronous) empties all stages, returns the escape
// state to idle and clears plus_as_space.
// ----------------------------------------------------------------------------
// url_percent_decoder
// Decodes URL percent escapes from a byte stream, optionally turning '+'
// into a space, and re-emits broken escapes with the first digit uppercase.
// ----------------------------------------------------------------------------
module url_percent_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  upd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output upd_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import upd_pkg::*;

    logic   plus_as_space_reg;
    logic   space;
    logic   burst_valid;
    burst_t burst;

    // The configuration register is always writable; software must write it only
    // while no request is in flight, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            plus_as_space_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            plus_as_space_reg <= cfg_data;
        end
    end

    // The decode stage holds one request in its input register and turns it
    // into a burst of zero to three bytes in a single combinational pass.
    upd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .plus_as_space (plus_as_space_reg),
        .space         (space),
        .burst_valid   (burst_valid),
        .burst         (burst)
    );

    // The emit stage registers the burst and drains it one byte per cycle while
    // out_stall is low, flagging the last byte of each request with run_last.
    upd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst       (burst),
        .space       (space),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
